### rtl/core/rpdgm_pkg.sv
// ----------------------------------------------------------------------------
// rpdgm_pkg
// Shared types and constants for the range packet deframer with grid marking.
// ----------------------------------------------------------------------------
`default_nettype none

package rpdgm_pkg;

  // register index codes (byte address = 4 * index)
  localparam logic [2:0] REG_HEADER     = 3'd0;
  localparam logic [2:0] REG_FOOTER     = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_ROW = 3'd3;
  localparam logic [2:0] REG_ORIGIN_COL = 3'd4;

  localparam logic [7:0]  HEADER_RST     = 8'd170;
  localparam logic [7:0]  FOOTER_RST     = 8'd85;
  localparam logic [15:0] CELL_SIZE_RST  = 16'd50;
  localparam logic [7:0]  ORIGIN_ROW_RST = 8'd0;
  localparam logic [7:0]  ORIGIN_COL_RST = 8'd128;

  localparam logic [15:0] NO_RETURN_MM = 16'hFFFF;
  localparam logic [15:0] MIN_RANGE_MM = 16'd30;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic [7:0]  header;
    logic [7:0]  footer;
    logic [15:0] cell_size;
    logic [7:0]  origin_row;
    logic [7:0]  origin_col;
  } cfg_t;

  typedef struct packed {
    logic       cap_id;
    logic       cap_dist_lo;
    logic       cap_dist_hi;
    logic       cap_time;
    logic [1:0] time_lane;
    logic       div_start;
    logic       div_step;
    logic       row_calc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic ftr_match;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/range_packet_deframer_grid_mark_unit.sv
// ----------------------------------------------------------------------------
// range_packet_deframer_grid_mark_unit
// Deframes range packets from a serial byte stream and builds grid marks.
// ----------------------------------------------------------------------------
// Each input word is one received byte. While hunting, every byte but the
// header value is dropped; after a header exactly PACKET_BYTES-1 more bytes
// are taken (header values inside the packet are plain data), the last of
// which must match the footer register or the packet is dropped silently.
// Ordinary bytes are taken at one per cycle. A good footer starts a
// restoring divide (distance / cell size, one quotient bit per cycle), then
// the grid row is formed, then the result loads into the output register;
// no input is taken from the footer until that load, which waits while the
// output register is still held by an untaken result. A result waiting in the
// output register does not stop the next packet's bytes. Zero cell size
// gives an all-ones quotient, so the row falls off the grid. Marks are
// suppressed for no-return (0xFFFF), ranges under 30 mm and off-grid cells;
// cell_index is then 0. Registers: header 0x00, footer 0x04, cell size 0x08,
// origin row 0x0C, origin column 0x10; write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module range_packet_deframer_grid_mark_unit #(
  parameter int PACKET_BYTES = 9,
  parameter int GRID_SIZE    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_point_id,
  output logic      [15:0] out_distance_mm,
  output logic      [31:0] out_timestamp_ms,
  output logic      [16:0] out_grid_row,
  output logic             out_mark_valid,
  output logic      [15:0] out_cell_index,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import rpdgm_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  rpdgm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: position count, divide steps, output handoff
  rpdgm_ctrl #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // capture, divider, row/cell math, output register
  rpdgm_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_id     (out_point_id),
    .out_distance_mm  (out_distance_mm),
    .out_timestamp_ms (out_timestamp_ms),
    .out_grid_row     (out_grid_row),
    .out_mark_valid   (out_mark_valid),
    .out_cell_index   (out_cell_index)
  );

  // an unmarked result carries a zero cell index
  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mark_valid) |-> (out_cell_index == 16'd0))
    else $error("cell index nonzero without mark");

  // a mark always lies on the grid and in range
  a_mark_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mark_valid) |->
      ((out_grid_row < 17'(GRID_SIZE)) && (out_distance_mm >= MIN_RANGE_MM) &&
       (out_distance_mm != NO_RETURN_MM)))
    else $error("mark raised for illegal cell");

  // a new result only loads at the end of a divide, when input is stalled
  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!in_ready && $past(!in_ready)))
    else $error("result loaded outside divide sequence");

endmodule

`default_nettype wire

### rtl/core/rpdgm_regs.sv
// ----------------------------------------------------------------------------
// rpdgm_regs
// APB-style configuration registers, one 32-bit slot per register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdgm_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [4:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic      [31:0]      cfg_prdata,
  output logic                  cfg_pready,
  output rpdgm_pkg::cfg_t       cfg
);
  import rpdgm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_HEADER:     cfg_nxt.header     = cfg_pwdata[7:0];
        REG_FOOTER:     cfg_nxt.footer     = cfg_pwdata[7:0];
        REG_CELL_SIZE:  cfg_nxt.cell_size  = cfg_pwdata[15:0];
        REG_ORIGIN_ROW: cfg_nxt.origin_row = cfg_pwdata[7:0];
        REG_ORIGIN_COL: cfg_nxt.origin_col = cfg_pwdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header     <= HEADER_RST;
      cfg_r.footer     <= FOOTER_RST;
      cfg_r.cell_size  <= CELL_SIZE_RST;
      cfg_r.origin_row <= ORIGIN_ROW_RST;
      cfg_r.origin_col <= ORIGIN_COL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEADER:     cfg_prdata = {24'd0, cfg_r.header};
      REG_FOOTER:     cfg_prdata = {24'd0, cfg_r.footer};
      REG_CELL_SIZE:  cfg_prdata = {16'd0, cfg_r.cell_size};
      REG_ORIGIN_ROW: cfg_prdata = {24'd0, cfg_r.origin_row};
      REG_ORIGIN_COL: cfg_prdata = {24'd0, cfg_r.origin_col};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rpdgm_ctrl.sv
// ----------------------------------------------------------------------------
// rpdgm_ctrl
// Packet sequencer: header hunt, byte position, divide and output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdgm_ctrl #(
  parameter int PACKET_BYTES = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rpdgm_pkg::stat_t stat,
  output rpdgm_pkg::cmd_t       cmd
);
  import rpdgm_pkg::*;

  localparam int POS_W = $clog2(PACKET_BYTES);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 in_acc;

  assign in_ready = (state_r == ST_RUN);
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_RUN: begin
        if (in_acc) begin
          if (pos_r == '0) begin
            if (stat.hdr_match) pos_nxt = POS_W'(1);
          end else if (pos_r < POS_W'(PACKET_BYTES - 1)) begin
            cmd.cap_id      = (pos_r == POS_W'(1));
            cmd.cap_dist_lo = (pos_r == POS_W'(2));
            cmd.cap_dist_hi = (pos_r == POS_W'(3));
            cmd.cap_time    = (pos_r >= POS_W'(4)) && (pos_r <= POS_W'(7));
            cmd.time_lane   = 2'(pos_r - POS_W'(4));
            pos_nxt         = pos_r + POS_W'(1);
          end else begin
            // footer slot: a mismatch just drops the packet
            pos_nxt = '0;
            if (stat.ftr_match) begin
              cmd.div_start = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        cmd.row_calc = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rpdgm_dp.sv
// ----------------------------------------------------------------------------
// rpdgm_dp
// Field capture, restoring divider, row/mark/cell math and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdgm_dp #(
  parameter int GRID_SIZE = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       in_rx_byte,
  input  wire rpdgm_pkg::cfg_t  cfg,
  input  wire rpdgm_pkg::cmd_t  cmd,
  output rpdgm_pkg::stat_t      stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       out_point_id,
  output logic      [15:0]      out_distance_mm,
  output logic      [31:0]      out_timestamp_ms,
  output logic      [16:0]      out_grid_row,
  output logic                  out_mark_valid,
  output logic      [15:0]      out_cell_index
);
  import rpdgm_pkg::*;

  logic [7:0]  id_r;
  logic [15:0] dist_r;
  logic [31:0] time_r;

  logic [15:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] shifted;
  logic [16:0] trial;
  logic [16:0] row_r;

  logic        mark;
  logic [15:0] cell_idx;

  logic        valid_r;
  logic [7:0]  o_id_r;
  logic [15:0] o_dist_r;
  logic [31:0] o_time_r;
  logic [16:0] o_row_r;
  logic        o_mark_r;
  logic [15:0] o_cell_r;

  assign stat.hdr_match = (in_rx_byte == cfg.header);
  assign stat.ftr_match = (in_rx_byte == cfg.footer);
  assign stat.out_busy  = valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.cap_id)      id_r         <= in_rx_byte;
    if (cmd.cap_dist_lo) dist_r[7:0]  <= in_rx_byte;
    if (cmd.cap_dist_hi) dist_r[15:8] <= in_rx_byte;
    if (cmd.cap_time)    time_r[cmd.time_lane*8 +: 8] <= in_rx_byte;
  end

  // restoring step; a zero divisor always subtracts, giving all ones
  assign shifted = {rem_r, quo_r[15]};
  assign trial   = shifted - {1'b0, cfg.cell_size};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (cmd.div_start) begin
      quo_nxt = dist_r;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (cmd.row_calc) row_r <= {9'd0, cfg.origin_row} + {1'b0, quo_r};
  end

  always_comb begin
    mark = (dist_r != NO_RETURN_MM) && (dist_r >= MIN_RANGE_MM) &&
           (row_r < 17'(GRID_SIZE)) && (9'(cfg.origin_col) < 9'(GRID_SIZE));
    cell_idx = mark ? 16'(32'(row_r) * 32'(GRID_SIZE) + 32'(cfg.origin_col)) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_id_r   <= id_r;
      o_dist_r <= dist_r;
      o_time_r <= time_r;
      o_row_r  <= row_r;
      o_mark_r <= mark;
      o_cell_r <= cell_idx;
    end
  end

  assign out_valid        = valid_r;
  assign out_point_id     = o_id_r;
  assign out_distance_mm  = o_dist_r;
  assign out_timestamp_ms = o_time_r;
  assign out_grid_row     = o_row_r;
  assign out_mark_valid   = o_mark_r;
  assign out_cell_index   = o_cell_r;

endmodule

`default_nettype wire
